>>> rtl/core/mied_pkg.sv
package mied_pkg;

   // Configuration register indexes
   localparam logic [7:0] CSR_LOCAL_ADDR   = 8'd0;
   localparam logic [7:0] CSR_REMOTE_ADDR  = 8'd1;
   localparam logic [7:0] CSR_IFACE_UP     = 8'd2;
   localparam logic [7:0] CSR_MONITOR_MODE = 8'd3;

   localparam int unsigned CSR_INDEX_W = 8;
   localparam int unsigned CSR_DATA_W  = 32;

   localparam logic [7:0]  SP_FLAG       = 8'h80;
   localparam logic [15:0] WORD_MASK     = 16'hffff;
   localparam logic [15:0] MIN_CLAIM_LEN = 16'd28;
   localparam logic [15:0] FULL_HDR_LEN  = 16'd32;
   localparam logic [3:0]  SHORT_STRIP   = 4'd8;
   localparam logic [3:0]  LONG_STRIP    = 4'd12;

   typedef enum logic [2:0] {
      ST_ACCEPTED  = 3'd0,
      ST_NOT_OURS  = 3'd1,
      ST_TOO_SHORT = 3'd2,
      ST_BAD_FLAGS = 3'd3,
      ST_TRUNCATED = 3'd4,
      ST_BAD_CSUM  = 3'd5
   } status_type;

   // Packed with the first field in the highest bits
   typedef struct packed {
      logic [31:0] orig_src;
      logic [31:0] orig_dst;
      logic [15:0] hdr_csum;
      logic [7:0]  hdr_flags;
      logic [7:0]  hdr_proto;
      logic [15:0] packet_len;
      logic [31:0] outer_dst;
      logic [31:0] outer_src;
   } req_type;

   typedef struct packed {
      logic [31:0] error_count;
      logic [47:0] good_bytes;
      logic [31:0] good_packets;
      logic        deliver;
      logic [3:0]  strip_len;
      logic [15:0] inner_len;
      logic [7:0]  inner_proto;
      logic [31:0] inner_dst;
      logic [31:0] inner_src;
      status_type  status;
   } rsp_type;

   typedef struct packed {
      logic [31:0] local_addr;
      logic [31:0] remote_addr;
      logic        iface_up;
      logic        monitor_mode;
   } cfg_type;

   // Verdict and rewritten header of one packet
   typedef struct packed {
      status_type  status;
      logic [31:0] inner_src;
      logic [31:0] inner_dst;
      logic [7:0]  inner_proto;
      logic [15:0] inner_len;
      logic [3:0]  strip_len;
      logic        deliver;
   } verdict_type;

   localparam int unsigned REQ_W = $bits(req_type);
   localparam int unsigned RSP_W = $bits(rsp_type);

endpackage

>>> rtl/core/mied_classify.sv
module mied_classify (
   input  mied_pkg::req_type     req,
   input  mied_pkg::cfg_type     cfg,
   output mied_pkg::verdict_type verdict
);
   import mied_pkg::*;

   logic        with_src;
   logic [18:0] sum_raw;
   logic [16:0] sum_fold1;
   logic [15:0] sum_fold2;
   logic        csum_ok;
   logic        claimed;
   logic [3:0]  strip;

   assign with_src = (req.hdr_flags == SP_FLAG);

   // Sum the header words, then fold the carries back in twice
   always_comb begin
      sum_raw = 19'({req.hdr_proto, req.hdr_flags}) + 19'(req.hdr_csum)
              + 19'(req.orig_dst[31:16]) + 19'(req.orig_dst[15:0]);
      if (with_src) begin
         sum_raw = sum_raw + 19'(req.orig_src[31:16]) + 19'(req.orig_src[15:0]);
      end
      sum_fold1 = 17'(sum_raw[15:0]) + 17'(sum_raw[18:16]);
      sum_fold2 = sum_fold1[15:0] + 16'(sum_fold1[16]);
   end

   assign csum_ok = (sum_fold2 == WORD_MASK);
   assign claimed = (cfg.local_addr != 32'd0) && (cfg.local_addr == req.outer_dst)
                 && (cfg.remote_addr == req.outer_src);
   assign strip   = with_src ? LONG_STRIP : SHORT_STRIP;

   always_comb begin
      verdict = '0;
      if (!cfg.iface_up) begin
         verdict.status = ST_NOT_OURS;
      end else if (req.packet_len < MIN_CLAIM_LEN) begin
         verdict.status = ST_TOO_SHORT;
      end else if (!claimed) begin
         verdict.status = ST_NOT_OURS;
      end else if ((req.hdr_flags & ~SP_FLAG) != 8'd0) begin
         verdict.status = ST_BAD_FLAGS;
      end else if (with_src && (req.packet_len < FULL_HDR_LEN)) begin
         verdict.status = ST_TRUNCATED;
      end else if (!csum_ok) begin
         verdict.status = ST_BAD_CSUM;
      end else begin
         verdict.status      = ST_ACCEPTED;
         verdict.inner_src   = with_src ? req.orig_src : req.outer_src;
         verdict.inner_dst   = req.orig_dst;
         verdict.inner_proto = req.hdr_proto;
         verdict.inner_len   = req.packet_len - 16'(strip);
         verdict.strip_len   = strip;
         verdict.deliver     = !cfg.monitor_mode;
      end
   end

endmodule

>>> rtl/core/mied_counters.sv
module mied_counters (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  mied_pkg::status_type status,
   input  logic [15:0]          inner_len,
   output logic [31:0]          good_packets_in,
   output logic [47:0]          good_bytes_in,
   output logic [31:0]          error_count_in
);
   import mied_pkg::*;

   logic [31:0] good_packets_ff;
   logic [47:0] good_bytes_ff;
   logic [31:0] error_count_ff;

   // Next values are also the values shown with the item that causes them
   always_comb begin
      good_packets_in = good_packets_ff;
      good_bytes_in   = good_bytes_ff;
      error_count_in  = error_count_ff;
      case (status)
         ST_ACCEPTED: begin
            good_packets_in = good_packets_ff + 32'd1;
            good_bytes_in   = good_bytes_ff + 48'(inner_len);
         end
         ST_BAD_FLAGS, ST_TRUNCATED, ST_BAD_CSUM: begin
            error_count_in = error_count_ff + 32'd1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         good_packets_ff <= '0;
         good_bytes_ff   <= '0;
         error_count_ff  <= '0;
      end else if (advance) begin
         good_packets_ff <= good_packets_in;
         good_bytes_ff   <= good_bytes_in;
         error_count_ff  <= error_count_in;
      end
   end

endmodule

>>> rtl/core/minimal_ip_encap_decapsulator.sv
// Channel  Ports              Direction  tdata / tuser contents
// req      req_t*             in         176-bit packet header fields, no tuser
// rsp      rsp_t*             out        208-bit verdict, rewritten header, counters
// csr      csr_we/index/wdata in         plain register write, no read-back
//
// One packet per clock while rsp does not stall: an input register, one pass of
// compare and checksum logic, and an output register. A result is valid on rsp
// once its req transaction has passed the input and then the output register.
// A stalled output holds its transaction while the input register still takes
// one more; req_tready drops only when both registers are full and rsp stalls.
// Synchronous active-high reset clears the valid flags, config and counters.
module minimal_ip_encap_decapsulator (
   input  logic                              clock,
   input  logic                              reset,
   // outer_src, outer_dst, packet_len, hdr_proto, hdr_flags, hdr_csum,
   // orig_dst, orig_src (from bit 0 up)
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [mied_pkg::REQ_W-1:0]        req_tdata,
   // status, inner_src, inner_dst, inner_proto, inner_len, strip_len,
   // deliver, good_packets, good_bytes, error_count (from bit 0 up)
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [mied_pkg::RSP_W-1:0]        rsp_tdata,
   input  logic                              csr_we,
   input  logic [mied_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [mied_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import mied_pkg::*;

   req_type     in_ff;
   logic        in_valid_ff;
   rsp_type     out_ff;
   rsp_type     out_in;
   logic        out_valid_ff;
   cfg_type     cfg_ff;
   verdict_type verdict;
   logic        out_free;
   logic        advance;
   logic [31:0] good_packets_in;
   logic [47:0] good_bytes_in;
   logic [31:0] error_count_in;

   // Output slot frees when empty or being drained this cycle
   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff;

   // Configuration writes; unknown indexes drop silently
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LOCAL_ADDR:   cfg_ff.local_addr   <= csr_wdata;
            CSR_REMOTE_ADDR:  cfg_ff.remote_addr  <= csr_wdata;
            CSR_IFACE_UP:     cfg_ff.iface_up     <= csr_wdata[0];
            CSR_MONITOR_MODE: cfg_ff.monitor_mode <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Input register: load on accept, empty when moved on
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_ff <= req_type'(req_tdata);
      end
   end

   mied_classify u_classify (
      .req     (in_ff),
      .cfg     (cfg_ff),
      .verdict (verdict)
   );

   // Counters advance only when the item moves into the output register
   mied_counters u_counters (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .status          (verdict.status),
      .inner_len       (verdict.inner_len),
      .good_packets_in (good_packets_in),
      .good_bytes_in   (good_bytes_in),
      .error_count_in  (error_count_in)
   );

   always_comb begin
      out_in.status       = verdict.status;
      out_in.inner_src    = verdict.inner_src;
      out_in.inner_dst    = verdict.inner_dst;
      out_in.inner_proto  = verdict.inner_proto;
      out_in.inner_len    = verdict.inner_len;
      out_in.strip_len    = verdict.strip_len;
      out_in.deliver      = verdict.deliver;
      out_in.good_packets = good_packets_in;
      out_in.good_bytes   = good_bytes_in;
      out_in.error_count  = error_count_in;
   end

   // Output register: hold while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

endmodule

>>> rtl/core/mied_checker.sv
module mied_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [mied_pkg::RSP_W-1:0]       rsp_tdata
);
   import mied_pkg::*;

   rsp_type rsp;
   assign rsp = rsp_type'(rsp_tdata);

   // Reset empties the output
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

   // A stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled rsp transaction changed");

   // An accepted request shows up on rsp
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> ##2 rsp_tvalid)
      else $error("accepted req transaction produced no rsp");

   // Rejected packets are not delivered and carry zero strip and inner lengths
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp.status != ST_ACCEPTED) |->
         !rsp.deliver && (rsp.strip_len == 4'd0) && (rsp.inner_len == 16'd0))
      else $error("rejected packet with header fields set");

   // Accepted packets strip 8 or 12 bytes
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp.status == ST_ACCEPTED) |->
         (rsp.strip_len == SHORT_STRIP) || (rsp.strip_len == LONG_STRIP))
      else $error("accepted packet with bad strip length");

endmodule

bind minimal_ip_encap_decapsulator mied_checker u_mied_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
